// ----- design/epc_pkg.sv -----
// shared types, constants and sine table builder for the epicycle phasor chain
package epc_pkg;

    // bank size and field widths
    localparam int unsigned MAX_CIRCLES     = 16;
    localparam int unsigned IDX_W           = $clog2(MAX_CIRCLES);
    localparam int unsigned CFG_W           = 5;
    localparam int unsigned PHASE_BITS      = 16;
    localparam int unsigned SPEED_W         = 16;
    localparam int unsigned RADIUS_W        = 24;
    localparam int unsigned TIP_W           = 29;
    localparam int unsigned FUNC_W          = 2;

    // sine table geometry
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned ROM_K_W         = SINE_TABLE_BITS;
    localparam int unsigned ROM_J_W         = SINE_TABLE_BITS - 1;
    localparam int unsigned ROM_M_W         = SINE_TABLE_BITS - 2;
    localparam int unsigned ROM_QUARTER     = 1 << ROM_M_W;
    localparam int unsigned MAG_W           = 17;
    localparam int unsigned PROD_W          = RADIUS_W + MAG_W;
    localparam int unsigned TERM_W          = PROD_W - 16;

    // stream widths
    localparam int unsigned IN_DATA_W       = 48;
    localparam int unsigned OUT_DATA_W      = 64;

    // configuration port
    localparam int unsigned REG_IDX_W       = 1;
    localparam int unsigned PADDR_W         = REG_IDX_W + 2;
    localparam int unsigned PDATA_W         = 32;
    localparam logic [REG_IDX_W-1:0] REG_CIRCLES_IN_USE = '0;
    localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(1);

    // phase reset value: a quarter turn
    localparam logic [PHASE_BITS-1:0] PHASE_RESET = PHASE_BITS'(1) << (PHASE_BITS - 2);

    // q30 magnitudes of the odd polynomial terms of sin(pi/2 * x)
    localparam logic [63:0] K1  = 64'd1686629713;
    localparam logic [63:0] K3  = 64'd693598668;
    localparam logic [63:0] K5  = 64'd85569306;
    localparam logic [63:0] K7  = 64'd5026995;
    localparam logic [63:0] K9  = 64'd172272;
    localparam logic [63:0] K11 = 64'd3864;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RESET = 2'd2
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ctrl_state_t;

    // control travelling with one circle through the pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             first;
        logic             last;
    } beat_ctl_t;

    typedef struct packed {
        logic      wr_circle;
        logic      clear_phases;
        beat_ctl_t issue;
    } dp_cmd_t;

    typedef struct packed {
        logic adv;
    } dp_stat_t;

    // quarter-wave sine in q16, evaluated at elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        x  = 64'(j) << (32 - SINE_TABLE_BITS);
        x2 = (x * x) >> 30;
        t  = K9 - ((x2 * K11) >> 30);
        t  = K7 - ((x2 * t) >> 30);
        t  = K5 - ((x2 * t) >> 30);
        t  = K3 - ((x2 * t) >> 30);
        t  = K1 - ((x2 * t) >> 30);
        v  = (x * t) >> 30;
        v  = (v + 64'd8192) >> 14;
        if (v > 64'd65536)
        begin
            v = 64'd65536;
        end
        return MAG_W'(v);
    endfunction

endpackage

// ----- design/epc_ctrl.sv -----
// controller: input handshake, command decode and circle sequencing
module epc_ctrl
    import epc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] in_func,
    output logic              in_ready,
    input  logic [CFG_W-1:0]  circles_cfg,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd
);

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [IDX_W-1:0] cfg_last_idx;
    logic             accept;
    logic             is_tick;

    // clamp the circle count to one..bank size, kept as last index
    always_comb
    begin
        if (circles_cfg == '0)
        begin
            cfg_last_idx = '0;
        end
        else if (circles_cfg > CFG_W'(MAX_CIRCLES))
        begin
            cfg_last_idx = IDX_W'(MAX_CIRCLES - 1);
        end
        else
        begin
            cfg_last_idx = IDX_W'(circles_cfg - CFG_W'(1));
        end
    end

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign is_tick = (in_func == FUNC_TICK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_tick)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stat.adv && (cnt_reg == last_idx_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready           = 1'b0;
        cmd.wr_circle      = 1'b0;
        cmd.clear_phases   = 1'b0;
        cmd.issue.valid    = 1'b0;
        cmd.issue.idx      = cnt_reg;
        cmd.issue.first    = (cnt_reg == '0);
        cmd.issue.last     = (cnt_reg == last_idx_reg);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready         = 1'b1;
                cmd.wr_circle    = in_valid && (in_func == FUNC_WRITE);
                cmd.clear_phases = in_valid && (in_func == FUNC_RESET);
            end
            ST_RUN:
            begin
                cmd.issue.valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // circle counter and latched count
    always_comb
    begin
        cnt_next      = cnt_reg;
        last_idx_next = last_idx_reg;
        if (accept && is_tick)
        begin
            cnt_next      = '0;
            last_idx_next = cfg_last_idx;
        end
        else if ((state_reg == ST_RUN) && stat.adv)
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            last_idx_reg <= last_idx_next;
        end
    end

endmodule

// ----- design/epc_datapath.sv -----
// datapath: circle tables, phase update, sine lookup, scaling and tip accumulation
module epc_datapath
    import epc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic [IDX_W-1:0]           in_circle_index,
    input  logic [RADIUS_W-1:0]        in_radius,
    input  logic signed [SPEED_W-1:0]  in_speed,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [IDX_W-1:0]           out_index,
    output logic signed [TIP_W-1:0]    out_x,
    output logic signed [TIP_W-1:0]    out_y,
    output logic                       out_last
);

    localparam logic [MAG_W-1:0] QSINE_TOP = quarter_sine(ROM_QUARTER);
    localparam logic signed [TIP_W-1:0] TIP_MAX = {1'b0, {(TIP_W-1){1'b1}}};
    localparam logic signed [TIP_W-1:0] TIP_MIN = {1'b1, {(TIP_W-1){1'b0}}};

    // circle tables
    logic [PHASE_BITS-1:0]      phase_table_reg [MAX_CIRCLES];
    logic signed [SPEED_W-1:0]  speed_table_reg [MAX_CIRCLES];
    logic [RADIUS_W-1:0]        radius_table_reg [MAX_CIRCLES];

    // pipeline stages
    beat_ctl_t                  p1_ctl_reg, p2_ctl_reg, p3_ctl_reg;
    logic [PHASE_BITS-1:0]      p1_phase_reg;
    logic [RADIUS_W-1:0]        p1_radius_reg, p2_radius_reg;
    logic [MAG_W-1:0]           p2_mag_reg [2];
    logic                       p2_neg_reg [2];
    logic [TERM_W-1:0]          p3_term_reg [2];
    logic                       p3_neg_reg [2];

    // output beat, which is also the running tip
    logic                       out_valid_reg;
    logic [IDX_W-1:0]           out_index_reg;
    logic                       out_last_reg;
    logic signed [TIP_W-1:0]    out_xy_reg [2];

    logic                       adv;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [ROM_K_W-1:0]         rom_k;
    logic [MAG_W-1:0]           qrom [ROM_QUARTER];
    logic [MAG_W-1:0]           lane_mag [2];
    logic                       lane_neg [2];
    logic [TERM_W-1:0]          lane_term [2];
    logic signed [TIP_W-1:0]    lane_tip [2];

    // whole pipeline moves when the output register is free or drained
    assign adv      = !out_valid_reg || out_ready;
    assign stat.adv = adv;

    // phase advance of the circle being issued
    assign phase_next = phase_table_reg[cmd.issue.idx]
                      + PHASE_BITS'(speed_table_reg[cmd.issue.idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CIRCLES; i++)
            begin
                phase_table_reg[i]  <= PHASE_RESET;
                speed_table_reg[i]  <= '0;
                radius_table_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear_phases)
            begin
                for (int i = 0; i < MAX_CIRCLES; i++)
                begin
                    phase_table_reg[i] <= PHASE_RESET;
                end
            end
            else if (adv && cmd.issue.valid)
            begin
                phase_table_reg[cmd.issue.idx] <= phase_next;
            end
            if (cmd.wr_circle && ({1'b0, in_circle_index} < (IDX_W+1)'(MAX_CIRCLES)))
            begin
                speed_table_reg[in_circle_index]  <= in_speed;
                radius_table_reg[in_circle_index] <= in_radius;
            end
        end
    end

    // quarter-wave sine table, built at elaboration
    for (genvar g = 0; g < ROM_QUARTER; g++)
    begin : g_qrom
        localparam logic [MAG_W-1:0] QVAL = quarter_sine(g);
        assign qrom[g] = QVAL;
    end

    assign rom_k = p1_phase_reg[PHASE_BITS-1 -: ROM_K_W];

    // lane 0 gives sine for x, lane 1 a quarter turn on for y
    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        localparam int unsigned OFS = ln * ROM_QUARTER;
        logic [ROM_K_W-1:0]  k;
        logic [ROM_M_W-1:0]  m;
        logic [ROM_J_W-1:0]  j;
        logic [PROD_W-1:0]   prod;
        logic [PROD_W-1:0]   prod_rnd;
        logic signed [TERM_W:0] term_s;
        logic signed [TIP_W:0]  base;
        logic signed [TIP_W:0]  sum;

        // fold the table index into the first quadrant
        assign k = rom_k + ROM_K_W'(OFS);
        assign m = k[ROM_M_W-1:0];
        assign j = k[ROM_K_W-2] ? (ROM_J_W'(ROM_QUARTER) - {1'b0, m}) : {1'b0, m};
        assign lane_mag[ln] = j[ROM_J_W-1] ? QSINE_TOP : qrom[j[ROM_M_W-1:0]];
        assign lane_neg[ln] = k[ROM_K_W-1];

        // radius times magnitude, rounded half up
        assign prod      = PROD_W'(p2_radius_reg) * PROD_W'(p2_mag_reg[ln]);
        assign prod_rnd  = prod + PROD_W'(32768);
        assign lane_term[ln] = prod_rnd[PROD_W-1:16];

        // signed add onto the previous tip, saturating
        assign term_s = p3_neg_reg[ln] ? -$signed({1'b0, p3_term_reg[ln]})
                                       : $signed({1'b0, p3_term_reg[ln]});
        assign base   = p3_ctl_reg.first ? '0 : (TIP_W+1)'(out_xy_reg[ln]);
        assign sum    = base + (TIP_W+1)'(term_s);
        assign lane_tip[ln] = (sum[TIP_W] != sum[TIP_W-1])
                            ? (sum[TIP_W] ? TIP_MIN : TIP_MAX)
                            : sum[TIP_W-1:0];
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg    <= '0;
            p2_ctl_reg    <= '0;
            p3_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_ctl_reg    <= cmd.issue;
            p2_ctl_reg    <= p1_ctl_reg;
            p3_ctl_reg    <= p2_ctl_reg;
            out_valid_reg <= p3_ctl_reg.valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_phase_reg  <= phase_next;
            p1_radius_reg <= radius_table_reg[cmd.issue.idx];
            p2_radius_reg <= p1_radius_reg;
            for (int ln = 0; ln < 2; ln++)
            begin
                p2_mag_reg[ln]  <= lane_mag[ln];
                p2_neg_reg[ln]  <= lane_neg[ln];
                p3_term_reg[ln] <= lane_term[ln];
                p3_neg_reg[ln]  <= p2_neg_reg[ln];
            end
            if (p3_ctl_reg.valid)
            begin
                out_index_reg <= p3_ctl_reg.idx;
                out_last_reg  <= p3_ctl_reg.last;
                out_xy_reg[0] <= lane_tip[0];
                out_xy_reg[1] <= lane_tip[1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;
    assign out_x     = out_xy_reg[0];
    assign out_y     = out_xy_reg[1];

endmodule

// ----- design/epicycle_phasor_chain.sv -----
// top level of the epicycle phasor chain: stream ports, register port, assertions
//
// Input stream (s_axis): one beat per command; tuser carries func (tick, write
// circle, reset phases), tdata carries circle_index, radius and speed.
// Output stream (m_axis): one beat per circle in use on a tick, giving the tip
// position of that circle; tlast marks the final circle of the tick.
// Register circles_in_use (address 0) sets how many circles a tick walks;
// zero acts as one, values above the bank size act as the bank size.
// Write circle and reset phases produce no output beats.
// On a tick the sequencer issues one circle per cycle, unless the output
// stalls, into a four stage pipeline (phase update, sine table, scaling
// multiply, saturating accumulate).
// After reset every phase is a quarter turn, speeds and radii are zero and
// circles_in_use is one; no clearing pass is needed.
// When the receiver holds tready low while an output beat is pending, the
// whole pipeline and the sequencer hold, and that beat stays steady until taken.
module epicycle_phasor_chain
    import epc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // circle_index[3:0], radius[27:4], speed[43:28]
    input  logic [FUNC_W-1:0]      s_axis_tuser,   // func[1:0]
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // tip_index[3:0], tip_x[32:4], tip_y[61:33]
    output logic                   m_axis_tlast,   // last
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int unsigned OUT_PAD = OUT_DATA_W - (IDX_W + 2 * TIP_W);

    logic [CFG_W-1:0]        circles_in_use_reg;
    logic                    cfg_write;
    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    logic [IDX_W-1:0]        tip_index;
    logic signed [TIP_W-1:0] tip_x;
    logic signed [TIP_W-1:0] tip_y;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circles_in_use_reg <= CFG_RESET;
        end
        else if (cfg_write && (paddr[PADDR_W-1:2] == REG_CIRCLES_IN_USE))
        begin
            circles_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_CIRCLES_IN_USE)
                  ? PDATA_W'(circles_in_use_reg) : '0;

    epc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_func     (s_axis_tuser),
        .in_ready    (s_axis_tready),
        .circles_cfg (circles_in_use_reg),
        .stat        (stat),
        .cmd         (cmd)
    );

    epc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_circle_index (s_axis_tdata[IDX_W-1:0]),
        .in_radius       (s_axis_tdata[IDX_W +: RADIUS_W]),
        .in_speed        (s_axis_tdata[IDX_W + RADIUS_W +: SPEED_W]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_index       (tip_index),
        .out_x           (tip_x),
        .out_y           (tip_y),
        .out_last        (m_axis_tlast)
    );

    // output beat packing
    assign m_axis_tdata = {{OUT_PAD{1'b0}}, tip_y, tip_x, tip_index};

    // no new command is taken while circles are being issued
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue.valid |-> !s_axis_tready)
        else $error("input taken while a tick is being issued");

    // table commands only come from an accepted beat
    a_cmd_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_circle || cmd.clear_phases) |-> (s_axis_tvalid && s_axis_tready))
        else $error("table command without an accepted beat");

    // the sequencer frees the input right after the last circle goes out
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue.valid && cmd.issue.last && stat.adv) |=> s_axis_tready)
        else $error("input not freed after final circle issued");

    // a tick always starts at circle zero
    a_first_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue.valid && cmd.issue.first) |-> (cmd.issue.idx == '0))
        else $error("tick started at a circle other than zero");

endmodule
